// ===== design/mbt_pkg.sv =====
// Package with the constants, types and state codes of the multichannel beep timer.
package mbt_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SEL_W = ((CH_IDX_W > 4) ? CH_IDX_W : 4) + 2;
    localparam int PAD_W = (MAX_CHANNELS > 8) ? MAX_CHANNELS : 8;

    localparam logic [7:0] PRESET_COUNT = 8'hFE;
    localparam logic [7:0] FOREVER_LIMIT = 8'd100;
    localparam logic [7:0] FOREVER_MARK = 8'hFF;
    localparam logic [3:0] ACTIVE_RESET = 4'd8;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_RING = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } mbt_state_t;

    typedef struct packed {
        logic [7:0] count;
        logic [7:0] left;
        logic [7:0] period;
    } chan_state_t;

    typedef struct packed {
        logic [7:0] count;
        logic [7:0] left;
        logic       toggle;
        logic       finish;
    } chan_step_t;

endpackage

// ===== design/mbt_chan_unit.sv =====
// Shared per-channel tick update unit, applied to one channel per cycle.
module mbt_chan_unit (
    input  mbt_pkg::chan_state_t cur,
    output mbt_pkg::chan_step_t  step
);
    import mbt_pkg::*;

    logic [7:0] count_inc;

    assign count_inc = cur.count + 8'd1;

    always_comb
    begin
        step.count  = cur.count;
        step.left   = cur.left;
        step.toggle = 1'b0;
        step.finish = 1'b0;
        if (cur.left != 8'd0)
        begin
            step.count = count_inc;
            if (count_inc > cur.period)
            begin
                step.count  = 8'd1;
                step.toggle = 1'b1;
                if (cur.left != FOREVER_MARK)
                begin
                    step.left   = cur.left - 8'd1;
                    step.finish = (cur.left == 8'd1);
                end
            end
        end
    end

endmodule

// ===== design/multichannel_beep_timer_top.sv =====
// Top level of the multichannel beep timer: sequencer, channel state and handshakes.
// A tick scans one channel per cycle, n being active_channels capped at the bank size; a
// ring command updates only the addressed channel. A new item is taken only after the
// result of the last one has been issued. A stalled result holds up the next one.
// Reset (rst_n low, asynchronous) turns all channels off, clears their state and
// sets active_channels to 8.
module multichannel_beep_timer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       command,
    input  logic [2:0] channel,
    input  logic [7:0] beep_count,
    input  logic [7:0] period_ticks,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] drive_levels,
    output logic [7:0] toggled_mask,
    output logic [7:0] finished_mask
);
    import mbt_pkg::*;

    mbt_state_t state_reg, state_next;
    logic [3:0] active_reg, active_next;
    logic [CH_IDX_W-1:0] idx_reg, idx_next;
    logic [7:0] count_reg [MAX_CHANNELS];
    logic [7:0] left_reg [MAX_CHANNELS];
    logic [7:0] period_reg [MAX_CHANNELS];
    logic [7:0] count_next [MAX_CHANNELS];
    logic [7:0] left_next [MAX_CHANNELS];
    logic [7:0] period_next [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] level_reg, level_next;
    logic [MAX_CHANNELS-1:0] tog_reg, tog_next;
    logic [MAX_CHANNELS-1:0] fin_reg, fin_next;
    logic result_valid_reg, result_valid_next;
    logic [7:0] drive_reg, drive_next;
    logic [7:0] tmask_reg, tmask_next;
    logic [7:0] fmask_reg, fmask_next;

    logic [SEL_W-1:0] scan_n;
    logic [CH_IDX_W-1:0] ring_idx;
    logic ring_ok;
    logic item_take;
    logic out_free;
    logic [PAD_W-1:0] level_pad, tog_pad, fin_pad;
    chan_state_t unit_in;
    chan_step_t unit_out;

    mbt_chan_unit u_unit (
        .cur  (unit_in),
        .step (unit_out)
    );

    assign cfg_ready = 1'b1;
    assign item_stall = (state_reg != ST_IDLE);
    assign item_take = item_valid && !item_stall;
    assign out_free = !result_valid_reg || !result_stall;

    assign scan_n = (SEL_W'(active_reg) > SEL_W'(MAX_CHANNELS)) ?
                    SEL_W'(MAX_CHANNELS) : SEL_W'(active_reg);
    assign ring_idx = CH_IDX_W'(channel);
    assign ring_ok = SEL_W'(channel) < SEL_W'(MAX_CHANNELS);

    assign unit_in.count = count_reg[idx_reg];
    assign unit_in.left = left_reg[idx_reg];
    assign unit_in.period = period_reg[idx_reg];

    assign level_pad = PAD_W'(level_reg);
    assign tog_pad = PAD_W'(tog_reg);
    assign fin_pad = PAD_W'(fin_reg);

    assign result_valid = result_valid_reg;
    assign drive_levels = drive_reg;
    assign toggled_mask = tmask_reg;
    assign finished_mask = fmask_reg;

    always_comb
    begin
        state_next = state_reg;
        active_next = active_reg;
        idx_next = idx_reg;
        count_next = count_reg;
        left_next = left_reg;
        period_next = period_reg;
        level_next = level_reg;
        tog_next = tog_reg;
        fin_next = fin_reg;
        result_valid_next = result_valid_reg;
        drive_next = drive_reg;
        tmask_next = tmask_reg;
        fmask_next = fmask_reg;

        if (cfg_valid && cfg_ready)
        begin
            active_next = cfg_data;
        end
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    tog_next = '0;
                    fin_next = '0;
                    idx_next = '0;
                    if (command == CMD_RING)
                    begin
                        if (ring_ok)
                        begin
                            level_next[ring_idx] = 1'b0;
                            count_next[ring_idx] = PRESET_COUNT;
                            left_next[ring_idx] = (beep_count > FOREVER_LIMIT) ?
                                                  FOREVER_MARK : {beep_count[6:0], 1'b0};
                            period_next[ring_idx] = period_ticks;
                            tog_next[ring_idx] = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else if (scan_n == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                count_next[idx_reg] = unit_out.count;
                left_next[idx_reg] = unit_out.left;
                level_next[idx_reg] = level_reg[idx_reg] ^ unit_out.toggle;
                tog_next[idx_reg] = unit_out.toggle;
                fin_next[idx_reg] = unit_out.finish;
                if (SEL_W'(idx_reg) + SEL_W'(1) >= scan_n)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CH_IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    drive_next = level_pad[7:0];
                    tmask_next = tog_pad[7:0];
                    fmask_next = fin_pad[7:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            active_reg <= ACTIVE_RESET;
            idx_reg <= '0;
            level_reg <= '0;
            tog_reg <= '0;
            fin_reg <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                count_reg[i] <= 8'd0;
                left_reg[i] <= 8'd0;
                period_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            active_reg <= active_next;
            idx_reg <= idx_next;
            level_reg <= level_next;
            tog_reg <= tog_next;
            fin_reg <= fin_next;
            result_valid_reg <= result_valid_next;
            count_reg <= count_next;
            left_reg <= left_next;
            period_reg <= period_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg <= drive_next;
        tmask_reg <= tmask_next;
        fmask_reg <= fmask_next;
    end

endmodule

// ===== dv/mbt_checker.sv =====
// Checker for the multichannel beep timer: watches the channels, predicts each result and compares it.
`timescale 1ns / 100ps

module mbt_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       item_valid,
    input  logic       item_stall,
    input  logic       command,
    input  logic [2:0] channel,
    input  logic [7:0] beep_count,
    input  logic [7:0] period_ticks,
    input  logic       result_valid,
    input  logic       result_stall,
    input  logic [7:0] drive_levels,
    input  logic [7:0] toggled_mask,
    input  logic [7:0] finished_mask,
    output int         fail_count,
    output int         pending,
    output int         results_checked,
    output int         toggle_events,
    output int         finish_events
);
    import mbt_pkg::*;

    typedef struct packed {
        logic [7:0] levels;
        logic [7:0] toggled;
        logic [7:0] finished;
    } bank_out_t;

    logic [7:0] tick_cnt    [MAX_CHANNELS];
    logic [7:0] budget      [MAX_CHANNELS];
    logic [7:0] half_period [MAX_CHANNELS];
    logic       drive       [MAX_CHANNELS];
    logic [3:0] scan_count;
    bank_out_t  bank_outputs_q [$];
    bank_out_t  want;
    int         mismatches;
    int         checked_n;
    int         toggles_n;
    int         finishes_n;

    function automatic bank_out_t step_bank(input logic cmd, input logic [2:0] ch,
                                            input logic [7:0] beeps, input logic [7:0] half);
        bank_out_t o;
        int        n;
        o = '0;
        if (cmd == CMD_RING)
        begin
            drive[ch] = 1'b0;
            tick_cnt[ch] = PRESET_COUNT;
            budget[ch] = (beeps > FOREVER_LIMIT) ? FOREVER_MARK : 8'(beeps << 1);
            half_period[ch] = half;
            o.toggled[ch] = 1'b1;
        end
        else
        begin
            n = (scan_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(scan_count);
            for (int c = 0; c < n; c++)
            begin
                if (budget[c] != 8'd0)
                begin
                    tick_cnt[c] = tick_cnt[c] + 8'd1;
                    if (tick_cnt[c] > half_period[c])
                    begin
                        tick_cnt[c] = 8'd1;
                        drive[c] = ~drive[c];
                        if (c < 8)
                            o.toggled[c] = 1'b1;
                        if (budget[c] != FOREVER_MARK)
                        begin
                            budget[c] = budget[c] - 8'd1;
                            if (budget[c] == 8'd0 && c < 8)
                                o.finished[c] = 1'b1;
                        end
                    end
                end
            end
        end
        for (int c = 0; c < MAX_CHANNELS && c < 8; c++)
            o.levels[c] = drive[c];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                tick_cnt[c] = 8'd0;
                budget[c] = 8'd0;
                half_period[c] = 8'd0;
                drive[c] = 1'b0;
            end
            scan_count = ACTIVE_RESET;
            bank_outputs_q.delete();
            mismatches = 0;
            checked_n = 0;
            toggles_n = 0;
            finishes_n = 0;
            fail_count <= 0;
            pending <= 0;
            results_checked <= 0;
            toggle_events <= 0;
            finish_events <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (bank_outputs_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result %h %h %h arrived with nothing expected",
                                 $time, drive_levels, toggled_mask, finished_mask);
                end
                else
                begin
                    want = bank_outputs_q.pop_front();
                    checked_n++;
                    toggles_n += $countones(want.toggled);
                    finishes_n += $countones(want.finished);
                    if (drive_levels !== want.levels || toggled_mask !== want.toggled ||
                        finished_mask !== want.finished)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("%0t: expected levels %h toggled %h finished %h, ",
                                   $time, want.levels, want.toggled, want.finished);
                            $display("got levels %h toggled %h finished %h",
                                     drive_levels, toggled_mask, finished_mask);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                scan_count = cfg_data;
            if (item_valid && !item_stall)
                bank_outputs_q.push_back(step_bank(command, channel, beep_count,
                                                   period_ticks));
            fail_count <= mismatches;
            pending <= bank_outputs_q.size();
            results_checked <= checked_n;
            toggle_events <= toggles_n;
            finish_events <= finishes_n;
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the multichannel beep timer: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
    import mbt_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int ITEMS_PER_PHASE = 160;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;
    logic       item_valid;
    logic       item_stall;
    logic       command;
    logic [2:0] channel;
    logic [7:0] beep_count;
    logic [7:0] period_ticks;
    logic       result_valid;
    logic       result_stall;
    logic [7:0] drive_levels;
    logic [7:0] toggled_mask;
    logic [7:0] finished_mask;

    int fail_count;
    int pending;
    int results_checked;
    int toggle_events;
    int finish_events;
    int hold_requests;
    int idle_cycles;
    int ring_items;
    int tick_items;
    logic [3:0] scan_plan [8] = '{4'd0, 4'd1, 4'd15, 4'd9, 4'd3, 4'd8, 4'd7, 4'd0};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multichannel_beep_timer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .channel       (channel),
        .beep_count    (beep_count),
        .period_ticks  (period_ticks),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .drive_levels  (drive_levels),
        .toggled_mask  (toggled_mask),
        .finished_mask (finished_mask)
    );

    mbt_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .command         (command),
        .channel         (channel),
        .beep_count      (beep_count),
        .period_ticks    (period_ticks),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .drive_levels    (drive_levels),
        .toggled_mask    (toggled_mask),
        .finished_mask   (finished_mask),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .toggle_events   (toggle_events),
        .finish_events   (finish_events)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic cmd, input logic [2:0] ch, input logic [7:0] beeps,
                             input logic [7:0] per, input bit burst);
        int gap;
        item_valid <= 1'b1;
        command <= cmd;
        channel <= ch;
        beep_count <= beeps;
        period_ticks <= per;
        if (cmd == CMD_RING)
            ring_items++;
        else
            tick_items++;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_scan_count(input logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(input int count, input int hold_at, input int pause_at);
        int         r;
        logic       cmd;
        logic [7:0] beeps;
        logic [7:0] per;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_requests <= hold_requests + 1;
            if (i == pause_at)
            begin
                item_valid <= 1'b0;
                drain_results();
            end
            cmd = ($urandom_range(0, 99) < 35) ? CMD_RING : CMD_TICK;
            r = $urandom_range(0, 99);
            if (r < 60)
                beeps = 8'($urandom_range(0, 4));
            else if (r < 75)
                beeps = 8'($urandom_range(95, 105));
            else
                beeps = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 70)
                per = 8'($urandom_range(0, 5));
            else if (r < 85)
                per = 8'($urandom_range(250, 255));
            else
                per = 8'($urandom_range(0, 255));
            send_item(cmd, 3'($urandom_range(0, 7)), beeps, per, i >= 100 && i < 140);
        end
    endtask

    // The receiver stalls in segments; a hold request from the stimulus side forces a
    // long stall so that the block backs up into its input.
    initial
    begin
        int holds_done;
        int r;
        int len;
        holds_done = 0;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                result_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    result_stall <= 1'b0;
                    len = $urandom_range(1, 20);
                end
                else if (r < 85)
                begin
                    result_stall <= 1'b1;
                    len = $urandom_range(1, 3);
                end
                else if (r < 97)
                begin
                    result_stall <= 1'b0;
                    len = $urandom_range(30, 80);
                end
                else
                begin
                    result_stall <= 1'b1;
                    len = $urandom_range(15, 50);
                end
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                 (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL multichannel_beep_timer_top");
                $finish;
            end
        end
    end

    initial
    begin
        hold_requests <= 0;
        ring_items = 0;
        tick_items = 0;
        cfg_valid <= 1'b0;
        cfg_data <= 4'd0;
        item_valid <= 1'b0;
        command <= CMD_TICK;
        channel <= 3'd0;
        beep_count <= 8'd0;
        period_ticks <= 8'd0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset scan count of eight.
        send_item(CMD_TICK, 3'd7, 8'd255, 8'd255, 1'b0);
        send_item(CMD_RING, 3'd0, 8'd1, 8'd0, 1'b0);
        send_item(CMD_TICK, 3'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_TICK, 3'd5, 8'd170, 8'd85, 1'b0);
        send_item(CMD_RING, 3'd1, 8'd0, 8'd3, 1'b0);
        send_item(CMD_RING, 3'd2, 8'd100, 8'd1, 1'b0);
        send_item(CMD_RING, 3'd3, 8'd101, 8'd2, 1'b0);
        send_item(CMD_RING, 3'd4, 8'd255, 8'd255, 1'b0);
        send_item(CMD_RING, 3'd5, 8'd2, 8'd254, 1'b0);
        send_item(CMD_RING, 3'd7, 8'd3, 8'd128, 1'b0);
        send_item(CMD_RING, 3'd6, 8'd85, 8'd170, 1'b0);
        repeat (5) send_item(CMD_TICK, 3'd0, 8'd0, 8'd0, 1'b0);
        send_item(CMD_RING, 3'd2, 8'd1, 8'd0, 1'b0);
        repeat (3) send_item(CMD_TICK, 3'd2, 8'd1, 8'd0, 1'b0);
        random_items(ITEMS_PER_PHASE, -1, -1);

        for (int p = 0; p < 8; p++)
        begin
            item_valid <= 1'b0;
            drain_results();
            write_scan_count((p == 7) ? 4'($urandom_range(0, 15)) : scan_plan[p]);
            random_items(ITEMS_PER_PHASE, (p == 2) ? 40 : -1, (p == 4) ? 80 : -1);
        end

        item_valid <= 1'b0;
        drain_results();
        repeat (20) @(posedge clk);

        $display("Sent %0d ticks and %0d ring commands across nine scan-count settings.",
                 tick_items, ring_items);
        $display("Checked %0d results with %0d drive toggles and %0d finished budgets.",
                 results_checked, toggle_events, finish_events);
        if (fail_count == 0 && pending == 0)
            $display("PASS multichannel_beep_timer_top");
        else
            $display("FAIL multichannel_beep_timer_top");
        $finish;
    end

endmodule
